// ===== rtl/core/vrt_pkg.sv =====
// Voxel ray traversal: shared types, codes and default sizes.
// Used by every module of the block; depends on nothing.
`default_nettype none

package vrt_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;
  localparam int STEP_BITS_DEF  = 16;

  localparam int SIDE_BITS  = 40;
  localparam int DELTA_BITS = 32;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_ANSWER = 1'b1;

  // face code adds this when the last step went toward positive
  localparam logic [2:0] FACE_POS_OFS = 3'd3;
  localparam logic [1:0] AXIS_X       = 2'd0;
  localparam logic [1:0] AXIS_Y       = 2'd1;
  localparam logic [1:0] AXIS_Z       = 2'd2;

  typedef enum logic [1:0] {
    KIND_REQ = 2'd0,
    KIND_HIT = 2'd1,
    KIND_END = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_SIDE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [15:0]        step_limit;
    logic               voxel_present;
    logic               voxel_solid;
    logic [31:0]        voxel_word;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [15:0] cell_z;
    logic [2:0]         face;
    logic [31:0]        hit_word;
  } out_item_t;

  typedef struct packed {
    logic       capture;
    logic       div_load;
    logic       div_iter;
    logic       mul;
    logic       side_load;
    logic       finish;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/voxel_ray_traversal.sv =====
// Voxel ray traversal top level: 3D DDA walker over an external voxel store.
// Depends on vrt_pkg, vrt_ctrl and vrt_datapath.
//
// Usage: send a start request (opcode 0) with origin, direction (signed
// fixed point, FRAC_BITS fraction bits) and a step limit. The block answers
// with one result: kind 0 asks for the voxel at cell_x/y/z, kind 2 ends.
// Send an answer request (opcode 1) with present/solid/word for the asked
// voxel; each answer gives exactly one result: the next voxel request, a hit
// (kind 1, face and block word) or an end (kind 2).
// Sequence: an answer goes from idle straight to the emit state. A start
// first runs the one-bit-per-cycle reciprocal divider shared across the
// three axes (per axis: load, divide, one multiply and one side load), then
// the emit state loads the result once the output register is free.
// One request is worked on at a time; in_ready is high only while idle, so
// the next request waits until the last one has left the emit state.
// The result sits in an output register; the next request is taken while
// it waits, but its own result holds until out_ready frees the register.
// Reset (rst_n low, synchronous) empties the output and drops any ray.
`default_nettype none

module voxel_ray_traversal #(
  parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = vrt_pkg::COORD_BITS_DEF,
  parameter int STEP_BITS  = vrt_pkg::STEP_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire vrt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output vrt_pkg::out_item_t      out_data
);

  vrt_pkg::cmd_t cmd;
  vrt_pkg::sts_t sts;

  vrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  vrt_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_BITS (COORD_BITS),
    .STEP_BITS  (STEP_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/vrt_ctrl.sv =====
// Voxel ray traversal controller: sequences setup, stepping and result hand-off.
// Depends on vrt_pkg; drives the datapath through vrt_pkg::cmd_t.
`default_nettype none

module vrt_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_opcode,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output vrt_pkg::cmd_t     cmd,
  input  wire vrt_pkg::sts_t sts
);

  vrt_pkg::state_t state_r, state_nxt;
  logic [1:0]      axis_r, axis_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      vrt_pkg::S_IDLE: begin
        if (in_valid) begin
          axis_nxt  = vrt_pkg::AXIS_X;
          state_nxt = (in_opcode == vrt_pkg::OP_START) ? vrt_pkg::S_LOAD : vrt_pkg::S_EMIT;
        end
      end
      vrt_pkg::S_LOAD: state_nxt = vrt_pkg::S_DIV;
      vrt_pkg::S_DIV: begin
        if (sts.div_done) state_nxt = vrt_pkg::S_MUL;
      end
      vrt_pkg::S_MUL: state_nxt = vrt_pkg::S_SIDE;
      vrt_pkg::S_SIDE: begin
        if (axis_r == vrt_pkg::AXIS_Z) begin
          state_nxt = vrt_pkg::S_EMIT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = vrt_pkg::S_LOAD;
        end
      end
      vrt_pkg::S_EMIT: begin
        if (slot_free) begin
          state_nxt     = vrt_pkg::S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = vrt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == vrt_pkg::S_IDLE);
    cmd           = '0;
    cmd.capture   = in_ready && in_valid;
    cmd.div_load  = (state_r == vrt_pkg::S_LOAD);
    cmd.div_iter  = (state_r == vrt_pkg::S_DIV) && !sts.div_done;
    cmd.mul       = (state_r == vrt_pkg::S_MUL);
    cmd.side_load = (state_r == vrt_pkg::S_SIDE);
    cmd.finish    = (state_r == vrt_pkg::S_EMIT) && slot_free;
    cmd.axis      = axis_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vrt_pkg::S_IDLE;
      axis_r      <= vrt_pkg::AXIS_X;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vrt_datapath.sv =====
// Voxel ray traversal datapath: ray state, shared reciprocal divider,
// side-distance multiplier, step logic and output register. Depends on vrt_pkg.
`default_nettype none

module vrt_datapath #(
  parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF,
  parameter int COORD_BITS = vrt_pkg::COORD_BITS_DEF,
  parameter int STEP_BITS  = vrt_pkg::STEP_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire vrt_pkg::in_item_t  in_data,
  input  wire vrt_pkg::cmd_t      cmd,
  output vrt_pkg::sts_t           sts,
  output vrt_pkg::out_item_t      out_data
);

  localparam int QW    = 2 * FRAC_BITS + 1;
  localparam int QX    = (QW > 32) ? QW : 33;
  localparam int CNT_W = $clog2(QW + 1);
  localparam int PW    = FRAC_BITS + 1 + vrt_pkg::DELTA_BITS;
  localparam int SW    = vrt_pkg::SIDE_BITS;

  vrt_pkg::in_item_t  item_r;
  vrt_pkg::out_item_t out_r, out_nxt;

  logic [31:0]      mag_r;
  logic [32:0]      rem_r;
  logic [QW-1:0]    quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PW-1:0]    prod_r;

  logic signed [COORD_BITS-1:0] cell_r [3];
  logic signed [COORD_BITS-1:0] cell_nxt [3];
  logic                         neg_r [3];
  logic                         neg_nxt [3];
  logic [31:0]                  delta_r [3];
  logic [SW-1:0]                side_r [3];
  logic [SW-1:0]                side_nxt [3];
  logic [STEP_BITS-1:0]         taken_r, taken_nxt;
  logic [STEP_BITS-1:0]         allowed_r, allowed_nxt;
  logic [1:0]                   last_r, last_nxt;
  logic                         active_r, active_nxt;

  logic signed [31:0] org_a [3];
  logic signed [31:0] dir_a [3];
  logic [31:0]        dsel;
  logic [32:0]        rem_sh;
  logic               qbit;
  logic [QX-1:0]      qx;
  logic [31:0]        delta_w;
  logic [FRAC_BITS:0] dist_w;
  logic [1:0]         ax;
  logic [SW:0]        side_sum;
  logic [1:0]         la;

  assign org_a[0] = item_r.origin_x;
  assign org_a[1] = item_r.origin_y;
  assign org_a[2] = item_r.origin_z;
  assign dir_a[0] = item_r.dir_x;
  assign dir_a[1] = item_r.dir_y;
  assign dir_a[2] = item_r.dir_z;

  assign dsel   = dir_a[cmd.axis];
  assign rem_sh = {rem_r[31:0], (cnt_r == '0)};
  assign qbit   = (rem_sh >= {1'b0, mag_r});
  assign qx     = QX'(quo_r);
  assign delta_w = ((mag_r == '0) || (|qx[QX-1:32])) ? 32'hFFFF_FFFF : qx[31:0];
  assign dist_w = dir_a[cmd.axis][31]
                ? {1'b0, org_a[cmd.axis][FRAC_BITS-1:0]}
                : ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, org_a[cmd.axis][FRAC_BITS-1:0]};

  assign sts.div_done = (cnt_r == CNT_W'(QW));
  assign out_data     = out_r;

  // result and state update for the held request
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cell_nxt[i] = cell_r[i];
      neg_nxt[i]  = neg_r[i];
      side_nxt[i] = side_r[i];
    end
    taken_nxt   = taken_r;
    allowed_nxt = allowed_r;
    last_nxt    = last_r;
    active_nxt  = active_r;
    out_nxt     = '0;
    out_nxt.kind = vrt_pkg::KIND_END;
    ax = (side_r[0] < side_r[1]) ? vrt_pkg::AXIS_X : vrt_pkg::AXIS_Y;
    if (side_r[2] < side_r[ax]) ax = vrt_pkg::AXIS_Z;
    side_sum = {1'b0, side_r[ax]} + (SW+1)'(delta_r[ax]);
    la = last_r;

    if (item_r.opcode == vrt_pkg::OP_START) begin
      for (int i = 0; i < 3; i++) begin
        cell_nxt[i] = COORD_BITS'(org_a[i] >>> FRAC_BITS);
        neg_nxt[i]  = dir_a[i][31];
      end
      taken_nxt   = '0;
      allowed_nxt = STEP_BITS'(item_r.step_limit);
      last_nxt    = vrt_pkg::AXIS_X;
      active_nxt  = (allowed_nxt != '0);
      if (active_nxt) begin
        out_nxt.kind   = vrt_pkg::KIND_REQ;
        out_nxt.cell_x = 16'(cell_nxt[0]);
        out_nxt.cell_y = 16'(cell_nxt[1]);
        out_nxt.cell_z = 16'(cell_nxt[2]);
      end
    end else if (active_r) begin
      if (!item_r.voxel_present) begin
        active_nxt = 1'b0;
      end else if (item_r.voxel_solid) begin
        active_nxt       = 1'b0;
        out_nxt.kind     = vrt_pkg::KIND_HIT;
        out_nxt.cell_x   = 16'(cell_r[0]);
        out_nxt.cell_y   = 16'(cell_r[1]);
        out_nxt.cell_z   = 16'(cell_r[2]);
        out_nxt.face     = {1'b0, la} + (neg_r[la] ? 3'd0 : vrt_pkg::FACE_POS_OFS);
        out_nxt.hit_word = item_r.voxel_word;
      end else begin
        if (neg_r[ax]) cell_nxt[ax] = cell_r[ax] - COORD_BITS'(1);
        else           cell_nxt[ax] = cell_r[ax] + COORD_BITS'(1);
        side_nxt[ax] = side_sum[SW] ? {SW{1'b1}} : side_sum[SW-1:0];
        last_nxt     = ax;
        taken_nxt    = taken_r + STEP_BITS'(1);
        if (taken_nxt < allowed_r) begin
          out_nxt.kind   = vrt_pkg::KIND_REQ;
          out_nxt.cell_x = 16'(cell_nxt[0]);
          out_nxt.cell_y = 16'(cell_nxt[1]);
          out_nxt.cell_z = 16'(cell_nxt[2]);
        end else begin
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.div_load) begin
      mag_r <= dsel[31] ? (~dsel + 32'd1) : dsel;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_iter) begin
      rem_r <= qbit ? (rem_sh - {1'b0, mag_r}) : rem_sh;
      quo_r <= {quo_r[QW-2:0], qbit};
    end
    if (cmd.mul) prod_r <= dist_w * delta_w;
    if (cmd.side_load) begin
      delta_r[cmd.axis] <= delta_w;
      side_r[cmd.axis]  <= SW'(prod_r >> FRAC_BITS);
    end
    if (cmd.finish) begin
      out_r <= out_nxt;
      for (int i = 0; i < 3; i++) begin
        cell_r[i] <= cell_nxt[i];
        neg_r[i]  <= neg_nxt[i];
        side_r[i] <= side_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      taken_r   <= '0;
      allowed_r <= '0;
      last_r    <= vrt_pkg::AXIS_X;
      active_r  <= 1'b0;
    end else begin
      if (cmd.div_load)      cnt_r <= '0;
      else if (cmd.div_iter) cnt_r <= cnt_r + CNT_W'(1);
      if (cmd.finish) begin
        taken_r   <= taken_nxt;
        allowed_r <= allowed_nxt;
        last_r    <= last_nxt;
        active_r  <= active_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/vrt_checker.sv =====
// Voxel ray traversal port checker and its bind to the top level.
// Depends on vrt_pkg and voxel_ray_traversal.
`default_nettype none

module vrt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire vrt_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == vrt_pkg::KIND_END |->
      out_data.cell_x == 16'sd0 && out_data.cell_y == 16'sd0 &&
      out_data.cell_z == 16'sd0 && out_data.face == 3'd0 && out_data.hit_word == 32'd0)
    else $error("end result carries data");

  a_req_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == vrt_pkg::KIND_REQ |->
      out_data.face == 3'd0 && out_data.hit_word == 32'd0)
    else $error("voxel request carries face or word");

  a_hit_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == vrt_pkg::KIND_HIT |-> out_data.face <= 3'd5)
    else $error("hit face out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken before the first finished");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for voxel_ray_traversal: random and directed ray walks checked
// against a cycle-free predictor of the DDA. Depends on vrt_pkg and the RTL.
`timescale 1ns / 100ps

module tb;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  vrt_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  vrt_pkg::out_item_t out_data;

  voxel_ray_traversal u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  // walker state of the predictor
  logic [15:0] wk_cell [3];
  logic        wk_neg [3];
  logic [31:0] wk_delta [3];
  logic [39:0] wk_side [3];
  logic [15:0] wk_taken, wk_allowed;
  logic [1:0]  wk_axis;
  logic        wk_active;

  vrt_pkg::in_item_t  pending_reqs[$];
  vrt_pkg::out_item_t expected_results[$];
  int                 mismatches = 0;
  int                 in_idle_pct = 0, out_idle_pct = 0;

  function automatic vrt_pkg::out_item_t make_result(vrt_pkg::kind_t k, bit cells,
                                                     logic [2:0] f, logic [31:0] w);
    vrt_pkg::out_item_t r;
    r.kind = k;
    r.cell_x = cells ? wk_cell[0] : '0;
    r.cell_y = cells ? wk_cell[1] : '0;
    r.cell_z = cells ? wk_cell[2] : '0;
    r.face = f;
    r.hit_word = w;
    return r;
  endfunction

  function automatic void init_axis(int a, logic [31:0] org, logic [31:0] dir);
    logic [32:0] mag;
    logic [63:0] dl;
    logic [16:0] span;
    logic [63:0] prod;
    wk_cell[a] = org[31:16];
    mag = dir[31] ? (33'h1_0000_0000 - {1'b0, dir}) : {1'b0, dir};
    if (mag == 0) dl = 64'hFFFF_FFFF;
    else begin
      dl = (64'd1 << 32) / mag;
      if (dl > 64'hFFFF_FFFF) dl = 64'hFFFF_FFFF;
    end
    wk_delta[a] = dl[31:0];
    wk_neg[a] = dir[31];
    span = dir[31] ? {1'b0, org[15:0]} : (17'h1_0000 - {1'b0, org[15:0]});
    prod = (64'(span) * 64'(dl[31:0])) >> 16;
    wk_side[a] = prod[39:0];
  endfunction

  function automatic vrt_pkg::out_item_t walk_step(vrt_pkg::in_item_t r);
    int   a;
    logic [40:0] s;
    if (r.opcode == vrt_pkg::OP_START) begin
      init_axis(0, r.origin_x, r.dir_x);
      init_axis(1, r.origin_y, r.dir_y);
      init_axis(2, r.origin_z, r.dir_z);
      wk_taken = 0;
      wk_allowed = r.step_limit;
      wk_axis = vrt_pkg::AXIS_X;
      wk_active = wk_allowed != 0;
      return wk_active ? make_result(vrt_pkg::KIND_REQ, 1, 0, 0)
                       : make_result(vrt_pkg::KIND_END, 0, 0, 0);
    end
    if (!wk_active || !r.voxel_present) begin
      wk_active = 0;
      return make_result(vrt_pkg::KIND_END, 0, 0, 0);
    end
    if (r.voxel_solid) begin
      wk_active = 0;
      return make_result(vrt_pkg::KIND_HIT, 1,
        3'(wk_axis) + (wk_neg[wk_axis] ? 3'd0 : vrt_pkg::FACE_POS_OFS), r.voxel_word);
    end
    a = (wk_side[0] < wk_side[1]) ? 0 : 1;
    if (wk_side[2] < wk_side[a]) a = 2;
    wk_cell[a] = wk_neg[a] ? wk_cell[a] - 1 : wk_cell[a] + 1;
    s = {1'b0, wk_side[a]} + 41'(wk_delta[a]);
    wk_side[a] = s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
    wk_axis = 2'(a);
    wk_taken = wk_taken + 1;
    if (wk_taken < wk_allowed) return make_result(vrt_pkg::KIND_REQ, 1, 0, 0);
    wk_active = 0;
    return make_result(vrt_pkg::KIND_END, 0, 0, 0);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
      default: return {{14{1'b0}}, 18'($urandom)} - 32'h0002_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return $urandom;
      2: return 32'h8000_0000;
      default: return {{15{1'b0}}, 17'($urandom)} - 32'h0001_0000;
    endcase
  endfunction

  function automatic vrt_pkg::in_item_t start_req(logic [15:0] lim);
    vrt_pkg::in_item_t r;
    r = vrt_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom});
    r.opcode = vrt_pkg::OP_START;
    r.origin_x = rand_coord(); r.origin_y = rand_coord(); r.origin_z = rand_coord();
    r.dir_x = rand_dir(); r.dir_y = rand_dir(); r.dir_z = rand_dir();
    r.step_limit = lim;
    return r;
  endfunction

  function automatic vrt_pkg::in_item_t answer_req(bit present, bit solid);
    vrt_pkg::in_item_t r;
    r = vrt_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom});
    r.opcode = vrt_pkg::OP_ANSWER;
    r.voxel_present = present;
    r.voxel_solid = solid;
    r.voxel_word = $urandom;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= $urandom_range(0, 99) >= out_idle_pct;
    end
  end

  // predict on accept, check on result
  always @(posedge clk) begin
    vrt_pkg::out_item_t e;
    if (rst_n && in_valid && in_ready) expected_results.push_back(walk_step(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        e = expected_results.pop_front();
        if (e !== out_data) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
  end

  task automatic add_walk(logic [15:0] lim, int answers);
    pending_reqs.push_back(start_req(lim));
    for (int i = 0; i < answers; i++) pending_reqs.push_back(answer_req(1, 0));
  endtask

  initial begin
    vrt_pkg::in_item_t r;
    int n;
    for (int a = 0; a < 3; a++) begin
      wk_cell[a] = 0; wk_neg[a] = 0; wk_delta[a] = 0; wk_side[a] = 0;
    end
    wk_taken = 0; wk_allowed = 0; wk_axis = vrt_pkg::AXIS_X; wk_active = 0;
    // directed: idle answer, zero limit, extremes, hit on first voxel, absent voxel
    pending_reqs.push_back(answer_req(1, 1));
    pending_reqs.push_back(start_req(16'd0));
    r = start_req(16'hFFFF);
    r.origin_x = 32'h8000_0000; r.origin_y = 32'h7FFF_FFFF; r.origin_z = 32'hFFFF_FFFF;
    r.dir_x = 32'h8000_0000; r.dir_y = 32'h7FFF_FFFF; r.dir_z = 32'h0;
    pending_reqs.push_back(r);
    pending_reqs.push_back(answer_req(1, 1));
    r.dir_x = 32'h0000_0001; r.dir_y = 32'hFFFF_FFFF; r.dir_z = 32'h0001_0000;
    pending_reqs.push_back(r);
    for (int i = 0; i < 6; i++) pending_reqs.push_back(answer_req(1, 0));
    pending_reqs.push_back(answer_req(1, 1));
    r.dir_x = 32'h0; r.dir_y = 32'h0; r.dir_z = 32'h0;
    r.step_limit = 16'd2;
    pending_reqs.push_back(r);
    pending_reqs.push_back(answer_req(1, 0));
    pending_reqs.push_back(answer_req(1, 0));
    pending_reqs.push_back(answer_req(0, 1));
    pending_reqs.push_back(start_req(16'd3));
    pending_reqs.push_back(answer_req(0, 0));
    add_walk(16'd1, 1);
    pending_reqs.push_back(start_req(16'd9));
    pending_reqs.push_back(start_req(16'd9)); // restart while active
    pending_reqs.push_back(answer_req(1, 1));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 55 : 0;
      out_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 35 : 0;
      n = 0;
      while (n < 380) begin
        if ($urandom_range(0, 9) == 0) begin
          pending_reqs.push_back($urandom_range(0, 1) ? answer_req($urandom, $urandom)
                                                      : start_req($urandom));
          n++;
        end else begin
          int len;
          len = $urandom_range(0, 12);
          pending_reqs.push_back(start_req($urandom_range(0, 15) == 0 ? $urandom
                                                                      : $urandom_range(0, 14)));
          for (int i = 0; i < len; i++)
            pending_reqs.push_back(answer_req($urandom_range(0, 19) != 0,
                                              $urandom_range(0, 7) == 0));
          n += len + 1;
        end
        while (pending_reqs.size() > 0) @(posedge clk);
      end
    end
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
